[hw/rtl/dps_pkg.sv]
`default_nettype none
package dps_pkg;

  localparam int MAX_DASHES = 8;
  localparam int DASH_BITS  = 8;

  // field and register widths
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 1;
  localparam int ENTRIES_W = 4;
  localparam int DIST_W    = 16;
  localparam int IDX_W     = 3;
  localparam int OFS_W     = 8;
  localparam int CNT_W     = 16;
  localparam int LEN_W     = 8;
  localparam int TOTAL_W   = $clog2(MAX_DASHES * ((1 << DASH_BITS) - 1) + 1);
  localparam int REM_W     = DIST_W + 1;
  localparam int MOD_BITS  = REM_W;
  localparam int MODCNT_W  = $clog2(MOD_BITS);

  localparam logic [LEN_W-1:0]     LEN_MASK      = LEN_W'((1 << DASH_BITS) - 1);
  localparam logic [ENTRIES_W-1:0] ENTRIES_RESET = ENTRIES_W'(2);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DASH_LENGTHS = 1'b0,
    REG_DASH_ENTRIES = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              restart;
  } in_word_t;

  typedef struct packed {
    logic [IDX_W-1:0] dash_position;
    logic [OFS_W-1:0] offset_in_dash;
    logic [CNT_W-1:0] dashes_passed;
    logic             pattern_error;
  } out_word_t;

  typedef struct packed {
    logic accept;
    logic step;
    logic mod_init;
    logic mod_step;
    logic walk_step;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic zero_total;
    logic fits;
    logic rem_ge_total;
    logic mod_last;
    logic walk_hit;
  } dp_status_t;

  function automatic logic [ENTRIES_W-1:0] count_eff(input logic [ENTRIES_W-1:0] entries);
    logic [ENTRIES_W-1:0] c;
    if (entries == '0) begin
      c = ENTRIES_W'(1);
    end else if (entries > ENTRIES_W'(MAX_DASHES)) begin
      c = ENTRIES_W'(MAX_DASHES);
    end else begin
      c = entries;
    end
    return c;
  endfunction

  function automatic logic [LEN_W-1:0] dash_len(input logic [CFG_W-1:0] lengths,
                                               input logic [IDX_W-1:0] idx);
    return lengths[{idx, 3'b000} +: LEN_W] & LEN_MASK;
  endfunction

  function automatic logic [IDX_W-1:0] next_entry(input logic [IDX_W-1:0]     idx,
                                                 input logic [ENTRIES_W-1:0] cnt);
    logic [ENTRIES_W-1:0] n;
    n = {1'b0, idx} + ENTRIES_W'(1);
    return (n >= cnt) ? '0 : n[IDX_W-1:0];
  endfunction

endpackage
`default_nettype wire

[hw/rtl/dps_ctrl.sv]
`default_nettype none
module dps_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  input  dps_pkg::dp_status_t  status_i,
  output dps_pkg::dp_cmd_t     cmd_o
);
  import dps_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_STEP,
    S_CHECK,
    S_MOD,
    S_WALK,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          state_d = S_STEP;
        end
      end
      S_STEP: begin
        cmd_o.step = 1'b1;
        state_d    = (status_i.zero_total || status_i.fits) ? S_DONE : S_CHECK;
      end
      S_CHECK: begin
        if (status_i.rem_ge_total) begin
          cmd_o.mod_init = 1'b1;
          state_d        = S_MOD;
        end else begin
          state_d = S_WALK;
        end
      end
      S_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (status_i.mod_last) begin
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        cmd_o.walk_step = 1'b1;
        if (status_i.walk_hit) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // load once the output register is empty or draining this cycle
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

[hw/rtl/dps_datapath.sv]
`default_nettype none
module dps_datapath (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [dps_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [dps_pkg::CFG_W-1:0]      cfg_data_i,
  input  dps_pkg::in_word_t                   in_word_i,
  input  dps_pkg::dp_cmd_t                    cmd_i,
  output dps_pkg::dp_status_t                 status_o,
  output dps_pkg::out_word_t                  out_word_o
);
  import dps_pkg::*;

  // configuration
  logic [CFG_W-1:0]     dash_lengths_q;
  logic [ENTRIES_W-1:0] dash_entries_q;
  logic [ENTRIES_W-1:0] cnt_eff;
  logic [TOTAL_W-1:0]   total_q, total_d;

  // architectural state
  logic [IDX_W-1:0] entry_q;
  logic [OFS_W-1:0] offset_q;
  logic [CNT_W-1:0] counter_q;
  logic             err_q;

  // working registers
  logic [DIST_W-1:0]   dist_q;
  logic [IDX_W-1:0]    idx_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [REM_W-1:0]    rem_q;
  logic [REM_W-1:0]    div_q;
  logic [TOTAL_W-1:0]  mod_r_q;
  logic [MODCNT_W-1:0] bit_q;
  out_word_t           out_q;

  // accept path
  logic [IDX_W-1:0] e_in;
  logic [OFS_W-1:0] o_in;
  logic [CNT_W-1:0] c_in;

  // first step
  logic [LEN_W-1:0] len_cur;
  logic [REM_W-1:0] sum;
  logic             fits;

  // modulo step
  logic [TOTAL_W:0] mod_t;
  logic [TOTAL_W:0] mod_n;

  // walk
  logic [LEN_W-1:0] len_w;
  logic             walk_hit;

  assign cnt_eff = count_eff(dash_entries_q);

  always_comb begin
    total_d = '0;
    for (int i = 0; i < MAX_DASHES; i++) begin
      if (ENTRIES_W'(i) < cnt_eff) begin
        total_d = total_d + TOTAL_W'(dash_len(dash_lengths_q, IDX_W'(i)));
      end
    end
  end

  always_comb begin
    e_in = in_word_i.restart ? '0 : entry_q;
    o_in = in_word_i.restart ? '0 : offset_q;
    c_in = in_word_i.restart ? '0 : counter_q;
    // entry count lowered under us: fall back to the first dash
    if ({1'b0, e_in} >= cnt_eff) begin
      e_in = '0;
      o_in = '0;
    end
  end

  assign len_cur  = dash_len(dash_lengths_q, entry_q);
  assign sum      = REM_W'(offset_q) + REM_W'(dist_q);
  assign fits     = sum < REM_W'(len_cur);

  assign mod_t    = {mod_r_q, div_q[REM_W-1]};
  assign mod_n    = (mod_t >= {1'b0, total_q}) ? mod_t - {1'b0, total_q} : mod_t;

  assign len_w    = dash_len(dash_lengths_q, idx_q);
  assign walk_hit = rem_q < REM_W'(len_w);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dash_lengths_q <= '0;
      dash_entries_q <= ENTRIES_RESET;
      total_q        <= '0;
      entry_q        <= '0;
      offset_q       <= '0;
      counter_q      <= '0;
      err_q          <= 1'b0;
      bit_q          <= '0;
    end else begin
      total_q <= total_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_DASH_LENGTHS: dash_lengths_q <= cfg_data_i;
          REG_DASH_ENTRIES: dash_entries_q <= cfg_data_i[ENTRIES_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.accept) begin
        entry_q   <= e_in;
        offset_q  <= o_in;
        counter_q <= c_in;
      end
      if (cmd_i.step) begin
        err_q <= (total_q == '0);
        if (total_q != '0 && fits) begin
          offset_q <= sum[OFS_W-1:0];
        end
      end
      if (cmd_i.mod_init) begin
        bit_q <= '0;
      end else if (cmd_i.mod_step) begin
        bit_q <= bit_q + MODCNT_W'(1);
      end
      if (cmd_i.walk_step && walk_hit) begin
        entry_q   <= idx_q;
        offset_q  <= rem_q[OFS_W-1:0];
        counter_q <= cnt_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      dist_q <= in_word_i.distance;
    end
    if (cmd_i.step) begin
      // leave the current dash, remainder carried into the walk
      rem_q <= sum - REM_W'(len_cur);
      cnt_q <= counter_q + CNT_W'(1);
      idx_q <= next_entry(entry_q, cnt_eff);
    end
    if (cmd_i.mod_init) begin
      div_q   <= rem_q;
      mod_r_q <= '0;
    end
    if (cmd_i.mod_step) begin
      div_q   <= {div_q[REM_W-2:0], 1'b0};
      mod_r_q <= mod_n[TOTAL_W-1:0];
      if (bit_q == MODCNT_W'(MOD_BITS - 1)) begin
        rem_q <= REM_W'(mod_n[TOTAL_W-1:0]);
      end
    end
    if (cmd_i.walk_step && !walk_hit) begin
      rem_q <= rem_q - REM_W'(len_w);
      cnt_q <= cnt_q + CNT_W'(1);
      idx_q <= next_entry(idx_q, cnt_eff);
    end
    if (cmd_i.out_load) begin
      out_q.dash_position  <= entry_q;
      out_q.offset_in_dash <= offset_q;
      out_q.dashes_passed  <= counter_q;
      out_q.pattern_error  <= err_q;
    end
  end

  assign status_o.zero_total   = (total_q == '0);
  assign status_o.fits         = fits;
  assign status_o.rem_ge_total = (REM_W'(total_q) <= rem_q);
  assign status_o.mod_last     = (bit_q == MODCNT_W'(MOD_BITS - 1));
  assign status_o.walk_hit     = walk_hit;

  assign out_word_o = out_q;

endmodule
`default_nettype wire

[hw/rtl/dash_pattern_stepper.sv]
// sequence: accept, first step, then the result register when the step stays in the current dash
// or the pattern sums to zero; otherwise a check, the bit-serial modulo by the pattern total when
// the leftover distance reaches it (one remainder bit per cycle), then a walk of one to eight dashes
// throughput: one word at a time, next word accepted the cycle after the result register loads
// reset: dash lengths 0, two entries in use, dash index, offset and counter all zero
`default_nettype none
module dash_pattern_stepper (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // configuration write port
  input  wire logic                           cfg_we_i,
  input  wire logic [dps_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [dps_pkg::CFG_W-1:0]      cfg_data_i,
  // input words
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  dps_pkg::in_word_t                   in_word_i,
  // result words
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output dps_pkg::out_word_t                  out_word_o
);
  import dps_pkg::*;

  // command and status between the sequencer and the datapath
  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer: accept, first step, modulo, dash walk, hand-off to output register
  dps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // datapath: config registers, pattern total, dash state, shift-subtract remainder,
  // one-dash-per-cycle walker and the output register
  dps_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_word_o  (out_word_o)
  );

endmodule
`default_nettype wire

[verif/dash_pattern_stepper_tb.sv]
module dash_pattern_stepper_tb;
  import dps_pkg::*;

  // no acceptance on either side for this many cycles ends the run
  localparam int QUIET_LIMIT  = 2000;
  // tail after the last result
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_WORDS = 1750;
  localparam int GAP_MAX      = 14;
  // mismatch lines past this many are counted but not printed
  localparam int LOG_CAP      = 100;

  typedef struct packed {
    in_word_t word;
    logic     drain;  // hold this word back until every result is in
  } queued_word_t;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_word_t             in_word   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_word_t            out_word;

  // mirror of the registers and of the walking position
  logic [CFG_W-1:0]     pat_lengths = '0;
  logic [ENTRIES_W-1:0] pat_entries = ENTRIES_RESET;
  logic [IDX_W-1:0]     pat_entry   = '0;
  logic [OFS_W-1:0]     pat_offset  = '0;
  logic [CNT_W-1:0]     pat_count   = '0;

  queued_word_t pending_words[$];
  out_word_t    due_results[$];
  queued_word_t head;
  out_word_t    want;

  // handshake bookkeeping shared between the edges
  bit          driving      = 1'b0;
  bit          word_taken   = 1'b0;
  bit          result_taken = 1'b0;
  int unsigned gap_left     = 0;
  int unsigned stall_left   = 0;
  int unsigned in_gap_max   = GAP_MAX;
  int unsigned out_gap_max  = GAP_MAX;
  int unsigned quiet        = 0;

  // run statistics
  int unsigned words_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches   = 0;
  int unsigned restarts     = 0;
  int unsigned zero_totals  = 0;
  int unsigned mod_wraps    = 0;
  int unsigned settings     = 0;

  dash_pattern_stepper dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  always #10 clk = ~clk;

  // length of one dash entry, byte idx of the packed register
  function automatic int unsigned seg_len(int unsigned idx);
    int unsigned len;
    len = pat_lengths[8*(idx % 8) +: 8];
    return len & ((1 << DASH_BITS) - 1);
  endfunction

  function automatic int unsigned wrap_next(int unsigned idx, int unsigned count);
    return (idx + 1 >= count) ? 0 : idx + 1;
  endfunction

  // advance the mirrored position by one word and return the expected result
  function automatic out_word_t step_pattern(in_word_t w);
    int unsigned count, total, ofs, span, rem, idx, cnt, len, k;
    bit          walking;
    out_word_t   r;
    if (w.restart) begin
      pat_entry  = '0;
      pat_offset = '0;
      pat_count  = '0;
      restarts++;
    end
    // entry count of zero acts as one, anything past the list saturates
    count = pat_entries;
    if (count == 0) count = 1;
    if (count > MAX_DASHES) count = MAX_DASHES;
    // count lowered under the current entry: start over at entry zero
    if (pat_entry >= count) begin
      pat_entry  = '0;
      pat_offset = '0;
    end
    total = 0;
    for (k = 0; k < count; k++) total += seg_len(k);
    ofs  = pat_offset;
    span = w.distance;
    r.pattern_error = 1'b0;
    if (total == 0) begin
      // nothing to walk: flag it, position stays put
      r.pattern_error = 1'b1;
      zero_totals++;
    end else if (ofs + span < seg_len(pat_entry)) begin
      pat_offset = OFS_W'(ofs + span);
    end else begin
      // leave the current dash; an offset past a shortened dash adds its excess
      rem = ofs + span - seg_len(pat_entry);
      cnt = pat_count + 1;
      idx = wrap_next(pat_entry, count);
      // whole pattern cycles are dropped without counting their dashes
      if (total <= rem) begin
        rem = rem % total;
        mod_wraps++;
      end
      // zero-length dashes are stepped over and still counted
      walking = 1'b1;
      for (k = 0; k <= count; k++) begin
        len = seg_len(idx);
        if (walking && rem >= len) begin
          rem -= len;
          cnt++;
          idx = wrap_next(idx, count);
        end else begin
          walking = 1'b0;
        end
      end
      pat_entry  = idx[IDX_W-1:0];
      pat_offset = rem[OFS_W-1:0];
      pat_count  = cnt[CNT_W-1:0];
    end
    r.dash_position  = pat_entry;
    r.offset_in_dash = pat_offset;
    r.dashes_passed  = pat_count;
    return r;
  endfunction

  task automatic flag_mismatch(string what, int unsigned got, int unsigned exp_val);
    if (mismatches < LOG_CAP)
      $display("mismatch on %s at result %0d: got %0d, want %0d",
               what, results_seen, got, exp_val);
    mismatches++;
  endtask

  task automatic send(logic [DIST_W-1:0] span, logic rs, logic drain = 1'b0);
    queued_word_t q;
    q.word.distance = span;
    q.word.restart  = rs;
    q.drain         = drain;
    pending_words.push_back(q);
  endtask

  // block is idle once every queued word went in and every result came out
  task automatic settle();
    while (pending_words.size() != 0 || driving || due_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_e which, logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= which;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (which == REG_DASH_LENGTHS) pat_lengths = value;
    else pat_entries = value[ENTRIES_W-1:0];
  endtask

  // sender: one word held until taken, then a random gap before the next
  always @(negedge clk) begin
    if (rst_n) begin
      if (word_taken) begin
        word_taken = 1'b0;
        driving    = 1'b0;
        gap_left   = $urandom_range(0, in_gap_max);
      end
      if (!driving) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_words.size() != 0 &&
                     !(pending_words[0].drain && due_results.size() != 0)) begin
          head    = pending_words.pop_front();
          driving = 1'b1;
        end
      end
      in_valid <= driving;
      in_word  <= head.word;
    end
  end

  // receiver: a fresh stall stretch is drawn after every result taken
  always @(negedge clk) begin
    if (rst_n) begin
      if (result_taken) begin
        result_taken = 1'b0;
        stall_left   = $urandom_range(0, out_gap_max);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left != 0);
    end
  end

  // monitor: predict on every accepted word, check every accepted result
  always @(posedge clk) begin
    if (rst_n) begin
      quiet++;
      if (in_valid && !in_stall) begin
        due_results.push_back(step_pattern(in_word));
        word_taken = 1'b1;
        words_sent++;
        quiet = 0;
      end
      if (out_valid && !out_stall) begin
        result_taken = 1'b1;
        results_seen++;
        quiet = 0;
        if (due_results.size() == 0) begin
          flag_mismatch("word with nothing pending", 1, 0);
        end else begin
          want = due_results.pop_front();
          if (out_word.dash_position != want.dash_position)
            flag_mismatch("dash_position", out_word.dash_position, want.dash_position);
          if (out_word.offset_in_dash != want.offset_in_dash)
            flag_mismatch("offset_in_dash", out_word.offset_in_dash, want.offset_in_dash);
          if (out_word.dashes_passed != want.dashes_passed)
            flag_mismatch("dashes_passed", out_word.dashes_passed, want.dashes_passed);
          if (out_word.pattern_error != want.pattern_error)
            flag_mismatch("pattern_error", out_word.pattern_error, want.pattern_error);
        end
      end
    end
  end

  initial begin : watchdog
    while (quiet < QUIET_LIMIT) @(posedge clk);
    $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    int unsigned left, n, k, b, sel;
    logic [CFG_W-1:0]  lens;
    logic [DIST_W-1:0] span;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset setting: all lengths zero, so every step flags an error
    send(16'd0, 1'b0);
    send(16'hFFFF, 1'b1);
    send(16'd7, 1'b0);
    settle();
    settings++;

    // lengths 3, 5, 0, 7: fit, exact boundary, zero dash crossed, modulo, restart
    write_reg(REG_DASH_LENGTHS, 64'h0000_0000_0700_0503);
    write_reg(REG_DASH_ENTRIES, 64'd4);
    send(16'd2, 1'b0);
    send(16'd1, 1'b0);
    send(16'd5, 1'b0, 1'b1);
    send(16'hFFFF, 1'b0);
    send(16'd0, 1'b1);
    settle();
    settings++;

    // widest pattern, park deep in the list at entry five
    write_reg(REG_DASH_LENGTHS, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_DASH_ENTRIES, 64'd8);
    send(16'hFFFF, 1'b1);
    send(16'd1278, 1'b1);
    settle();
    settings++;

    // count lowered under the current entry, then sit at offset 200
    write_reg(REG_DASH_ENTRIES, 64'd2);
    send(16'd10, 1'b0);
    send(16'd200, 1'b1);
    settle();
    settings++;

    // dash shortened under the offset: the excess carries into the walk
    write_reg(REG_DASH_LENGTHS, 64'h0000_0000_0000_140A);
    send(16'd1, 1'b0);
    settle();
    settings++;

    // entry count zero acts as one entry
    write_reg(REG_DASH_ENTRIES, 64'd0);
    send(16'd25, 1'b0);
    send(16'hFFFF, 1'b0);
    settle();
    settings++;

    // entry count past the list saturates
    write_reg(REG_DASH_LENGTHS, 64'h0102_0408_1020_4080);
    write_reg(REG_DASH_ENTRIES, 64'd15);
    send(16'd300, 1'b0);
    send(16'h8000, 1'b0);
    send(16'h7FFF, 1'b1);
    settle();
    settings++;

    // single dash of length one
    write_reg(REG_DASH_LENGTHS, 64'h0000_0000_0000_0001);
    write_reg(REG_DASH_ENTRIES, 64'd1);
    send(16'hFFFF, 1'b0);
    send(16'd0, 1'b0);
    settle();
    settings++;

    // zero total without restart keeps the position
    write_reg(REG_DASH_LENGTHS, 64'd0);
    send(16'd3, 1'b0);
    settle();
    settings++;

    // random phases: new setting, idle style and a burst of words each
    left = RANDOM_WORDS;
    while (left > 0) begin
      for (b = 0; b < MAX_DASHES; b++) begin
        sel = $urandom_range(0, 7);
        if (sel == 0) lens[8*b +: 8] = 8'd0;
        else if (sel < 4) lens[8*b +: 8] = 8'($urandom_range(1, 8));
        else if (sel == 4) lens[8*b +: 8] = 8'hFF;
        else lens[8*b +: 8] = 8'($urandom_range(0, 255));
      end
      if ($urandom_range(0, 11) == 0) lens = '0;
      if ($urandom_range(0, 3) != 0) write_reg(REG_DASH_LENGTHS, lens);
      if ($urandom_range(0, 3) != 0)
        write_reg(REG_DASH_ENTRIES, ($urandom_range(0, 9) == 0) ?
                  $urandom_range(0, 15) : $urandom_range(1, 8));
      settings++;

      // each side idles or runs flat out, so some phases have no gaps at all
      in_gap_max  = $urandom_range(0, 1) ? GAP_MAX : 0;
      out_gap_max = $urandom_range(0, 1) ? GAP_MAX : 0;

      n = $urandom_range(20, 80);
      if (n > left) n = left;
      for (k = 0; k < n; k++) begin
        sel = $urandom_range(0, 9);
        if (sel < 5) span = DIST_W'($urandom_range(0, 40));
        else if (sel < 8) span = DIST_W'($urandom_range(0, 600));
        else if (sel == 8) span = DIST_W'($urandom);
        else span = 16'hFFFF - DIST_W'($urandom_range(0, 3));
        send(span, $urandom_range(0, 7) == 0, $urandom_range(0, 39) == 0);
      end
      left -= n;
      settle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (due_results.size() != 0)
      flag_mismatch("results never produced", 0, due_results.size());

    $display("covered %0d words over %0d dash settings: %0d restarts, %0d zero-total steps,",
             words_sent, settings, restarts, zero_totals);
    $display("%0d steps through the modulo path, %0d results checked, %0d mismatches",
             mod_wraps, results_seen, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
